### hdl/uvcr_pkg.sv
`timescale 1ns / 1ps

package uvcr_pkg;

    // request kinds carried on the input tuser
    typedef enum logic [1:0] {
        CMD_CLEAR   = 2'd0,
        CMD_MARK    = 2'd1,
        CMD_COMPACT = 2'd2,
        CMD_RENAME  = 2'd3
    } cmd_t;

    // fixed field widths
    localparam int INDEX_W = 12;
    localparam int COORD_W = 32;
    localparam int VALUE_W = 16;
    localparam int SIZE_W  = 13;

    // packed stream widths
    localparam int S_DATA_W = 112;
    localparam int M_DATA_W = 128;

    // table size after reset and kept count ceiling
    localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd4096;
    localparam logic [SIZE_W-1:0] NEXT_MAX   = 13'd8191;

endpackage

### hdl/uvcr_table.sv
`timescale 1ns / 1ps

module uvcr_table #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 16,
    parameter int AW    = 12
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

### hdl/unused_vertex_compaction_remap.sv
`timescale 1ns / 1ps
// channel  dir  handshake            contents
// s_*      in   s_tvalid / s_tready  tuser: cmd; tdata: index, point_x, point_y, point_z
// m_*      out  m_tvalid / m_tready  tuser: kept; tdata: value, out_x, out_y, out_z, kept_total
// cfg_*    in   cfg_we               table_size
//
// mark, compact and rename read the table as the request is taken, then modify and
// write back in ST_EXEC; one request is in flight at a time.
// clear takes the request, then zeroes one entry per cycle up to table_size (clamped to
// TABLE_DEPTH) before it answers; a clear of size zero answers in the next cycle.
// after reset a clearing pass zeroes all TABLE_DEPTH entries, one per cycle, with
// s_tready low; table_size resets to 4096.
// a new request is taken while the previous result waits, provided that result
// leaves the output register in the same cycle or earlier.

module unused_vertex_compaction_remap
    import uvcr_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096,
    parameter int COUNT_WIDTH = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration
    input  logic                 cfg_we,
    input  logic [SIZE_W-1:0]    cfg_wdata,   // table_size
    // request stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_DATA_W-1:0]  s_tdata,     // index[11:0], point_x, point_y, point_z, pad
    input  logic [1:0]           s_tuser,     // cmd[1:0]
    // result stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,     // value[15:0], out_x, out_y, out_z, kept_total, pad
    output logic                 m_tuser      // kept
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CLEAR,
        ST_INIT
    } state_t;

    state_t                 state_reg, state_next;
    cmd_t                   cmd_reg, cmd_next;
    logic                   ok_reg, ok_next;
    logic [COORD_W-1:0]     x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [AW-1:0]          addr_reg, addr_next;
    logic [AW-1:0]          clr_cnt_reg, clr_cnt_next;
    logic [SIZE_W-1:0]      next_index_reg, next_index_next;
    logic [SIZE_W-1:0]      table_size_reg, table_size_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [VALUE_W-1:0]     m_value_reg, m_value_next;
    logic                   m_kept_reg, m_kept_next;
    logic [COORD_W-1:0]     m_x_reg, m_x_next, m_y_reg, m_y_next, m_z_reg, m_z_next;
    logic [SIZE_W-1:0]      m_total_reg, m_total_next;

    logic [SIZE_W-1:0]      eff_size;
    logic                   s_fire;
    logic [INDEX_W-1:0]     s_index;
    cmd_t                   s_cmd;
    logic                   clr_last;
    logic                   init_last;
    logic                   tbl_we;
    logic [AW-1:0]          tbl_waddr;
    logic [COUNT_WIDTH-1:0] tbl_wdata;
    logic [COUNT_WIDTH-1:0] tbl_rdata;
    logic [COUNT_WIDTH-1:0] entry_new;

    // effective table size, clamped to the table depth
    always_comb
    begin
        if (32'(table_size_reg) > 32'(TABLE_DEPTH))
        begin
            eff_size = SIZE_W'(TABLE_DEPTH);
        end
        else
        begin
            eff_size = table_size_reg;
        end
    end

    assign s_index   = s_tdata[INDEX_W-1:0];
    assign s_cmd     = cmd_t'(s_tuser);
    assign s_tready  = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_fire    = s_tvalid && s_tready;
    assign clr_last  = (32'(clr_cnt_reg) + 32'd1) == 32'(eff_size);
    assign init_last = (32'(clr_cnt_reg) + 32'd1) == 32'(TABLE_DEPTH);

    uvcr_table #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (COUNT_WIDTH),
        .AW    (AW)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (AW'(s_index)),
        .rdata (tbl_rdata)
    );

    // next state, table writes and result loading
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        ok_next         = ok_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        z_next          = z_reg;
        addr_next       = addr_reg;
        clr_cnt_next    = clr_cnt_reg;
        next_index_next = next_index_reg;
        table_size_next = table_size_reg;
        m_tvalid_next   = m_tvalid_reg;
        m_value_next    = m_value_reg;
        m_kept_next     = m_kept_reg;
        m_x_next        = m_x_reg;
        m_y_next        = m_y_reg;
        m_z_next        = m_z_reg;
        m_total_next    = m_total_reg;
        tbl_we          = 1'b0;
        tbl_waddr       = addr_reg;
        tbl_wdata       = '0;
        entry_new       = tbl_rdata;

        // configuration write
        if (cfg_we)
        begin
            table_size_next = cfg_wdata;
        end

        // result taken downstream
        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    cmd_next  = s_cmd;
                    ok_next   = {1'b0, s_index} < eff_size;
                    x_next    = s_tdata[INDEX_W +: COORD_W];
                    y_next    = s_tdata[INDEX_W + COORD_W +: COORD_W];
                    z_next    = s_tdata[INDEX_W + 2 * COORD_W +: COORD_W];
                    addr_next = AW'(s_index);
                    if (s_cmd == CMD_CLEAR)
                    begin
                        clr_cnt_next = '0;
                        if (eff_size == '0)
                        begin
                            // nothing to walk, answer at once
                            next_index_next = '0;
                            m_tvalid_next   = 1'b1;
                            m_value_next    = '0;
                            m_kept_next     = 1'b0;
                            m_x_next        = '0;
                            m_y_next        = '0;
                            m_z_next        = '0;
                            m_total_next    = '0;
                        end
                        else
                        begin
                            state_next = ST_CLEAR;
                        end
                    end
                    else
                    begin
                        state_next = ST_EXEC;
                    end
                end
            end

            ST_EXEC:
            begin
                m_tvalid_next = 1'b1;
                m_value_next  = '0;
                m_kept_next   = 1'b0;
                m_x_next      = '0;
                m_y_next      = '0;
                m_z_next      = '0;
                case (cmd_reg)
                    CMD_MARK:
                    begin
                        if (ok_reg)
                        begin
                            if (tbl_rdata != CNT_MAX)
                            begin
                                entry_new = tbl_rdata + COUNT_WIDTH'(1);
                            end
                            tbl_we       = 1'b1;
                            tbl_wdata    = entry_new;
                            m_value_next = VALUE_W'(entry_new);
                        end
                    end
                    CMD_COMPACT:
                    begin
                        if (ok_reg && tbl_rdata != '0)
                        begin
                            entry_new    = COUNT_WIDTH'(next_index_reg);
                            tbl_we       = 1'b1;
                            tbl_wdata    = entry_new;
                            m_value_next = VALUE_W'(entry_new);
                            m_kept_next  = 1'b1;
                            m_x_next     = x_reg;
                            m_y_next     = y_reg;
                            m_z_next     = z_reg;
                            if (next_index_reg != NEXT_MAX)
                            begin
                                next_index_next = next_index_reg + SIZE_W'(1);
                            end
                        end
                    end
                    CMD_RENAME:
                    begin
                        if (ok_reg)
                        begin
                            m_value_next = VALUE_W'(tbl_rdata);
                        end
                    end
                    default:
                    begin
                        m_value_next = '0;
                    end
                endcase
                m_total_next = next_index_next;
                state_next   = ST_IDLE;
            end

            ST_CLEAR:
            begin
                // one entry zeroed per cycle
                tbl_we       = 1'b1;
                tbl_waddr    = clr_cnt_reg;
                tbl_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_last)
                begin
                    next_index_next = '0;
                    m_tvalid_next   = 1'b1;
                    m_value_next    = '0;
                    m_kept_next     = 1'b0;
                    m_x_next        = '0;
                    m_y_next        = '0;
                    m_z_next        = '0;
                    m_total_next    = '0;
                    state_next      = ST_IDLE;
                end
            end

            ST_INIT:
            begin
                // whole table zeroed once after reset, no result
                tbl_we       = 1'b1;
                tbl_waddr    = clr_cnt_reg;
                tbl_wdata    = '0;
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (init_last)
                begin
                    clr_cnt_next = '0;
                    state_next   = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            cmd_reg        <= CMD_CLEAR;
            ok_reg         <= 1'b0;
            x_reg          <= '0;
            y_reg          <= '0;
            z_reg          <= '0;
            addr_reg       <= '0;
            clr_cnt_reg    <= '0;
            next_index_reg <= '0;
            table_size_reg <= SIZE_RESET;
            m_tvalid_reg   <= 1'b0;
            m_value_reg    <= '0;
            m_kept_reg     <= 1'b0;
            m_x_reg        <= '0;
            m_y_reg        <= '0;
            m_z_reg        <= '0;
            m_total_reg    <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cmd_reg        <= cmd_next;
            ok_reg         <= ok_next;
            x_reg          <= x_next;
            y_reg          <= y_next;
            z_reg          <= z_next;
            addr_reg       <= addr_next;
            clr_cnt_reg    <= clr_cnt_next;
            next_index_reg <= next_index_next;
            table_size_reg <= table_size_next;
            m_tvalid_reg   <= m_tvalid_next;
            m_value_reg    <= m_value_next;
            m_kept_reg     <= m_kept_next;
            m_x_reg        <= m_x_next;
            m_y_reg        <= m_y_next;
            m_z_reg        <= m_z_next;
            m_total_reg    <= m_total_next;
        end
    end

    // result packing
    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_kept_reg;
    assign m_tdata  = {3'b000, m_total_reg, m_z_reg, m_y_reg, m_x_reg, m_value_reg};

    // one request in flight: a request that uses the table blocks the next cycle
    a_single_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_fire && (s_cmd != CMD_CLEAR || eff_size != '0)) |=> !s_tready)
        else $error("request accepted while previous one still in progress");

    // a kept point always leaves a nonzero kept total
    a_kept_total: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && m_kept_reg) |-> (m_total_reg != '0))
        else $error("kept point with zero kept total");

    // clear walk stays inside the active part of the table
    a_clear_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (32'(clr_cnt_reg) < 32'(eff_size)))
        else $error("clear walk beyond table size");

    // the result register is never loaded over a result still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC) |-> (!m_tvalid_reg || m_tready))
        else $error("result register busy when table access completes");

endmodule
